@@ sv/ndpe_pkg.sv @@
// ----------------------------------------------------------------------------
// ndpe_pkg
// Shared types and constants for the neighbour-discovery encapsulator.
// ----------------------------------------------------------------------------
package ndpe_pkg;

    localparam int unsigned HoldWords = 10;
    localparam int unsigned NumRegs   = 8;

    typedef logic [HoldWords-1:0][63:0] t_hold;
    typedef logic [NumRegs-1:0][63:0]   t_regs;

    // Register indexes
    localparam logic [3:0] REG_LOCAL_PUBLIC_HI  = 4'd0;
    localparam logic [3:0] REG_LOCAL_PUBLIC_LO  = 4'd1;
    localparam logic [3:0] REG_PEER_PUBLIC_HI   = 4'd2;
    localparam logic [3:0] REG_PEER_PUBLIC_LO   = 4'd3;
    localparam logic [3:0] REG_LOCAL_TARGET_HI  = 4'd4;
    localparam logic [3:0] REG_LOCAL_TARGET_LO  = 4'd5;
    localparam logic [3:0] REG_REMOTE_TARGET_HI = 4'd6;
    localparam logic [3:0] REG_REMOTE_TARGET_LO = 4'd7;

    // Result action codes
    localparam logic [1:0] ACT_PASS  = 2'd0;
    localparam logic [1:0] ACT_ENCAP = 2'd1;
    localparam logic [1:0] ACT_DROP  = 2'd2;

    // Frame modes
    localparam logic [1:0] MODE_CLASSIFY = 2'd0;
    localparam logic [1:0] MODE_PASS     = 2'd1;
    localparam logic [1:0] MODE_ENCAP    = 2'd2;
    localparam logic [1:0] MODE_DISCARD  = 2'd3;

    localparam logic [15:0] ETHERTYPE_IPV6  = 16'h86DD;
    localparam logic [7:0]  NH_ICMPV6       = 8'd58;
    localparam logic [7:0]  NH_IPV6         = 8'd41;
    localparam logic [7:0]  OUTER_HOPS      = 8'd64;
    localparam logic [7:0]  ICMP_NSOL       = 8'd135;
    localparam logic [7:0]  ICMP_NADV       = 8'd136;
    localparam logic [6:0]  MIN_BYTES       = 7'd78;
    localparam logic [15:0] MAX_INNER_LEN   = 16'd65495;
    localparam logic [15:0] OUTER_HDR_BYTES = 16'd40;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] plen;
    } t_class;

endpackage

@@ sv/ndpe_cfg.sv @@
// ----------------------------------------------------------------------------
// ndpe_cfg
// Configuration register file: eight 64-bit registers written by index.
// ----------------------------------------------------------------------------
module ndpe_cfg import ndpe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output t_regs       o_regs
);

    t_regs r_regs;

    assign o_cfg_ready = 1'b1;
    assign o_regs      = r_regs;

    // Write a register; ignore indexes beyond the file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= '0;
        end else if (i_cfg_valid && (i_cfg_index < 4'(NumRegs))) begin
            r_regs[i_cfg_index[2:0]] <= i_cfg_data;
        end
    end

endmodule

@@ sv/ndpe_class.sv @@
// ----------------------------------------------------------------------------
// ndpe_class
// Frame classifier: decides pass, encapsulate or drop from the held words.
// ----------------------------------------------------------------------------
module ndpe_class import ndpe_pkg::*; (
    input  t_hold      i_hold,
    input  t_regs      i_regs,
    input  logic [6:0] i_nbytes,
    output t_class     o_class
);

    logic [15:0] ethertype;
    logic [3:0]  version;
    logic [7:0]  next_hdr;
    logic [7:0]  msg_type;
    logic [15:0] inner_len;
    logic [63:0] tgt_hi;
    logic [63:0] tgt_lo;
    logic        hdr_ok;
    logic        tgt_ok;

    // Pick the header fields out of the held words
    always_comb begin
        ethertype = i_hold[1][31:16];
        version   = i_hold[1][15:12];
        inner_len = i_hold[2][47:32];
        next_hdr  = i_hold[2][31:24];
        msg_type  = i_hold[6][15:8];
        tgt_hi    = {i_hold[7][15:0], i_hold[8][63:16]};
        tgt_lo    = {i_hold[8][15:0], i_hold[9][63:16]};
    end

    // Check the header, match the target against the address for the message type, and pick the action
    always_comb begin
        hdr_ok = (i_nbytes >= MIN_BYTES) && (ethertype == ETHERTYPE_IPV6)
                 && (version == 4'd6) && (next_hdr == NH_ICMPV6);
        if (msg_type == ICMP_NSOL) begin
            tgt_ok = (tgt_hi == i_regs[REG_REMOTE_TARGET_HI[2:0]])
                     && (tgt_lo == i_regs[REG_REMOTE_TARGET_LO[2:0]]);
        end else if (msg_type == ICMP_NADV) begin
            tgt_ok = (tgt_hi == i_regs[REG_LOCAL_TARGET_HI[2:0]])
                     && (tgt_lo == i_regs[REG_LOCAL_TARGET_LO[2:0]]);
        end else begin
            tgt_ok = 1'b0;
        end
        o_class.plen = inner_len + OUTER_HDR_BYTES;
        if (!(hdr_ok && tgt_ok)) begin
            o_class.action = ACT_PASS;
        end else if (inner_len > MAX_INNER_LEN) begin
            o_class.action = ACT_DROP;
        end else begin
            o_class.action = ACT_ENCAP;
        end
    end

endmodule

@@ sv/ndp_ipv6_in_ipv6_encapsulator.sv @@
// ----------------------------------------------------------------------------
// ndp_ipv6_in_ipv6_encapsulator
// Encapsulates matching neighbour-discovery frames in an outer IPv6 header.
// ----------------------------------------------------------------------------
// Frames enter as 8-byte words, one word per cycle unless the input is
// stalled. The first ten words (or the whole frame if shorter) are held in a
// register bank, then classified and sent out from that bank, one word per
// cycle unless the output stalls, while the input is stalled: n words for a
// passed frame, 15 for an encapsulated one, a single marker for a dropped
// one. After that, the rest of a passed or encapsulated frame flows through
// the output register at one word per cycle unless the output stalls, and
// the rest of a dropped frame is discarded. Output back-pressure stalls the input.
module ndp_ipv6_in_ipv6_encapsulator import ndpe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // in_word[63:0], in_count[67:64], zero[71:68]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // out_word[63:0], out_count[67:64], zero[71:68]
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser,   // out_action[1:0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    t_regs       regs;
    t_class      cls;
    t_hold       r_hold;
    logic [1:0]  r_mode,  n_mode;
    logic [3:0]  r_widx;
    logic        r_emit;
    logic [3:0]  r_k;
    logic [3:0]  r_idx;
    logic [3:0]  r_eff;
    logic        r_last;
    logic        r_ov;
    logic [63:0] r_ow;
    logic [3:0]  r_oc;
    logic        r_ol;
    logic [1:0]  r_oa;

    logic        ld, acc;
    logic [63:0] in_word;
    logic [3:0]  in_cnt, eff;
    logic [6:0]  nbytes;
    logic [3:0]  len_m1;
    logic [3:0]  hidx;
    logic [63:0] hw, ew;
    logic [3:0]  ec;
    logic        el;

    ndpe_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_regs      (regs)
    );

    assign nbytes = {1'b0, r_idx[2:0], 3'b000} + (r_idx[3] ? 7'd64 : 7'd0) + 7'(r_eff);

    ndpe_class u_class (
        .i_hold   (r_hold),
        .i_regs   (regs),
        .i_nbytes (nbytes),
        .o_class  (cls)
    );

    // Unpack input and clamp the byte count
    assign in_word = s_axis_tdata[63:0];
    assign in_cnt  = s_axis_tdata[67:64];
    assign eff     = (s_axis_tlast && in_cnt != 4'd0 && in_cnt <= 4'd8) ? in_cnt : 4'd8;

    assign ld = !r_ov || m_axis_tready;
    assign s_axis_tready = !r_emit && ((r_mode == MODE_CLASSIFY) || (r_mode == MODE_DISCARD)
                                       || ld);
    assign acc = s_axis_tvalid && s_axis_tready;

    // Build the emitted word from the held bank and the address registers, and pick the next mode
    always_comb begin
        hidx = (cls.action == ACT_ENCAP) ? (r_k - 4'd5) : r_k;
        hw   = r_hold[(hidx < 4'(HoldWords)) ? hidx : 4'd0];
        unique case (cls.action)
            ACT_ENCAP: len_m1 = r_idx + 4'd5;
            ACT_DROP:  len_m1 = 4'd0;
            default:   len_m1 = r_idx;
        endcase
        el = (r_k == len_m1);
        ec = (el ? r_eff : 4'd8);
        ew = hw;
        if (cls.action == ACT_DROP) begin
            ew = '0;
            ec = 4'd0;
        end else if (cls.action == ACT_ENCAP) begin
            unique case (r_k)
                4'd0: ew = {r_hold[0][15:0], r_hold[1][63:32], r_hold[0][15:0]};
                4'd1: ew = {r_hold[1][63:16], 16'h6000};
                4'd2: ew = {16'h0000, cls.plen, NH_IPV6, OUTER_HOPS,
                            regs[REG_LOCAL_PUBLIC_HI[2:0]][63:48]};
                4'd3: ew = {regs[REG_LOCAL_PUBLIC_HI[2:0]][47:0],
                            regs[REG_LOCAL_PUBLIC_LO[2:0]][63:48]};
                4'd4: ew = {regs[REG_LOCAL_PUBLIC_LO[2:0]][47:0],
                            regs[REG_PEER_PUBLIC_HI[2:0]][63:48]};
                4'd5: ew = {regs[REG_PEER_PUBLIC_HI[2:0]][47:0],
                            regs[REG_PEER_PUBLIC_LO[2:0]][63:48]};
                4'd6: ew = {regs[REG_PEER_PUBLIC_LO[2:0]][47:0], r_hold[1][15:0]};
                default: ew = hw;
            endcase
        end
        if (r_last) begin
            n_mode = MODE_CLASSIFY;
        end else begin
            unique case (cls.action)
                ACT_ENCAP: n_mode = MODE_ENCAP;
                ACT_DROP:  n_mode = MODE_DISCARD;
                default:   n_mode = MODE_PASS;
            endcase
        end
    end

    // Hold words and sequence the emission
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_CLASSIFY;
            r_widx <= '0;
            r_emit <= 1'b0;
            r_k    <= '0;
        end else if (r_emit) begin
            if (ld) begin
                r_k <= r_k + 4'd1;
                if (el) begin
                    r_emit <= 1'b0;
                    r_mode <= n_mode;
                end
            end
        end else if (acc) begin
            if (r_mode == MODE_CLASSIFY) begin
                if (s_axis_tlast || r_widx == 4'(HoldWords - 1)) begin
                    r_emit <= 1'b1;
                    r_k    <= '0;
                    r_widx <= '0;
                end else begin
                    r_widx <= r_widx + 4'd1;
                end
            end else if (s_axis_tlast) begin
                r_mode <= MODE_CLASSIFY;
            end
        end
    end

    // Hold bank and frame-end details, no reset needed
    always_ff @(posedge i_clk) begin
        if (acc && r_mode == MODE_CLASSIFY) begin
            r_hold[r_widx] <= in_word;
            r_idx  <= r_widx;
            r_eff  <= eff;
            r_last <= s_axis_tlast;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_emit && ld) begin
            r_ov <= 1'b1;
        end else if (acc && (r_mode == MODE_PASS || r_mode == MODE_ENCAP)) begin
            r_ov <= 1'b1;
        end else if (ld) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_emit && ld) begin
            r_ow <= ew;
            r_oc <= ec;
            r_ol <= (cls.action == ACT_DROP) ? 1'b1 : (el && r_last);
            r_oa <= cls.action;
        end else if (acc && (r_mode == MODE_PASS || r_mode == MODE_ENCAP)) begin
            r_ow <= in_word;
            r_oc <= eff;
            r_ol <= s_axis_tlast;
            r_oa <= (r_mode == MODE_ENCAP) ? ACT_ENCAP : ACT_PASS;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {4'b0000, r_oc, r_ow};
    assign m_axis_tlast  = r_ol;
    assign m_axis_tuser  = r_oa;

endmodule

@@ sv/ndpe_checker.sv @@
// ----------------------------------------------------------------------------
// ndpe_checker
// Port-level checks on the encapsulator's result stream.
// ----------------------------------------------------------------------------
module ndpe_checker import ndpe_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [1:0]  m_axis_tuser
);

    // A drop marker is an empty, final word
    a_drop_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ACT_DROP
        |-> m_axis_tdata[67:64] == 4'd0 && m_axis_tlast)
        else $error("drop marker malformed");

    // Every word that is not a drop marker carries bytes
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ACT_DROP
        |-> m_axis_tdata[67:64] != 4'd0 && m_axis_tdata[67:64] <= 4'd8)
        else $error("bad byte count");

    // Hold a stalled word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled word changed");

endmodule

bind ndp_ipv6_in_ipv6_encapsulator ndpe_checker u_ndpe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the neighbour-discovery IPv6-in-IPv6 encapsulator.
// Frames of random length and content are streamed in, many of them well-formed
// solicitations and advertisements that match the configured targets. A
// scoreboard predicts every output word and compares it field by field.
// ----------------------------------------------------------------------------
module testbench;
    import ndpe_pkg::*;

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  count;
        logic        last;
        logic [1:0]  action;
    } t_out_word;

    // Frame encapsulation predictor and queue of expected output words
    class ndp_scoreboard;
        logic [63:0] regs [8];
        logic [63:0] held [10];
        int unsigned held_idx;
        logic [1:0]  mode;
        logic [15:0] carry;
        t_out_word   pending_words [$];
        int          errors;

        function void reset_state();
            for (int i = 0; i < 8; i++) regs[i] = '0;
            for (int i = 0; i < 10; i++) held[i] = '0;
            held_idx = 0;
            mode = MODE_CLASSIFY;
            carry = '0;
            pending_words.delete();
            errors = 0;
        endfunction

        function logic [7:0] held_byte(int unsigned off);
            logic [63:0] w;
            w = held[(off >> 3) % 10];
            return w[56 - 8 * (off & 7) +: 8];
        endfunction

        function logic [63:0] held_quad(int unsigned off);
            logic [63:0] v;
            v = '0;
            for (int i = 0; i < 8; i++) v = {v[55:0], held_byte(off + i)};
            return v;
        endfunction

        function void push(logic [63:0] w, logic [3:0] c, logic l, logic [1:0] a);
            t_out_word o;
            o.word = w; o.count = c; o.last = l; o.action = a;
            pending_words.push_back(o);
        endfunction

        function logic [1:0] classify(int unsigned nbytes, output logic [15:0] plen);
            logic [7:0] mtype;
            plen = '0;
            if (nbytes < 78) return ACT_PASS;
            if ({held_byte(12), held_byte(13)} != ETHERTYPE_IPV6) return ACT_PASS;
            if (held_byte(14) >> 4 != 4'd6) return ACT_PASS;
            if (held_byte(20) != NH_ICMPV6) return ACT_PASS;
            mtype = held_byte(54);
            plen = {held_byte(18), held_byte(19)};
            if (mtype == ICMP_NSOL) begin
                if (held_quad(62) != regs[REG_REMOTE_TARGET_HI] ||
                    held_quad(70) != regs[REG_REMOTE_TARGET_LO]) return ACT_PASS;
            end else if (mtype == ICMP_NADV) begin
                if (held_quad(62) != regs[REG_LOCAL_TARGET_HI] ||
                    held_quad(70) != regs[REG_LOCAL_TARGET_LO]) return ACT_PASS;
            end else begin
                return ACT_PASS;
            end
            if (plen > MAX_INNER_LEN) return ACT_DROP;
            return ACT_ENCAP;
        endfunction

        // Note one accepted input word
        function void note_input(logic [63:0] w, logic [3:0] c_in, logic l);
            logic [3:0]  c;
            int unsigned idx, n;
            logic [1:0]  act;
            logic [15:0] plen;
            logic [63:0] h0, h1, shi, slo, dhi, dlo;
            logic [47:0] mac_src;
            logic [31:0] pl32;
            c = (c_in < 1 || c_in > 8 || !l) ? 4'd8 : c_in;
            if (mode == MODE_PASS || mode == MODE_ENCAP) begin
                push(w, c, l, mode == MODE_ENCAP ? ACT_ENCAP : ACT_PASS);
                if (l) mode = MODE_CLASSIFY;
                return;
            end
            if (mode == MODE_DISCARD) begin
                if (l) mode = MODE_CLASSIFY;
                return;
            end
            idx = held_idx;
            held[idx] = w;
            if (idx == 1) carry = w[15:0];
            if (!l && idx < 9) begin
                held_idx = idx + 1;
                return;
            end
            held_idx = 0;
            n = idx + 1;
            act = classify(idx * 8 + c, plen);
            if (act == ACT_PASS) begin
                for (int i = 0; i < n; i++)
                    push(held[i], i == n - 1 ? c : 4'd8, i == n - 1 ? l : 1'b0, ACT_PASS);
                mode = l ? MODE_CLASSIFY : MODE_PASS;
            end else if (act == ACT_DROP) begin
                push('0, 4'd0, 1'b1, ACT_DROP);
                mode = l ? MODE_CLASSIFY : MODE_DISCARD;
            end else begin
                h0 = held[0]; h1 = held[1];
                mac_src = {h0[15:0], h1[63:32]};
                pl32 = 32'(plen) + 32'(OUTER_HDR_BYTES);
                shi = regs[REG_LOCAL_PUBLIC_HI]; slo = regs[REG_LOCAL_PUBLIC_LO];
                dhi = regs[REG_PEER_PUBLIC_HI];  dlo = regs[REG_PEER_PUBLIC_LO];
                push({mac_src, h0[15:0]}, 4'd8, 1'b0, ACT_ENCAP);
                push({h1[63:16], 16'h6000}, 4'd8, 1'b0, ACT_ENCAP);
                push({pl32, NH_IPV6, OUTER_HOPS, shi[63:48]}, 4'd8, 1'b0, ACT_ENCAP);
                push({shi[47:0], slo[63:48]}, 4'd8, 1'b0, ACT_ENCAP);
                push({slo[47:0], dhi[63:48]}, 4'd8, 1'b0, ACT_ENCAP);
                push({dhi[47:0], dlo[63:48]}, 4'd8, 1'b0, ACT_ENCAP);
                push({dlo[47:0], carry}, 4'd8, 1'b0, ACT_ENCAP);
                for (int i = 2; i < n; i++)
                    push(held[i], i == n - 1 ? c : 4'd8, i == n - 1 ? l : 1'b0, ACT_ENCAP);
                mode = l ? MODE_CLASSIFY : MODE_ENCAP;
            end
        endfunction

        // Check one accepted output word against the oldest expectation
        function void check_output(t_out_word got);
            t_out_word exp_w;
            if (pending_words.size() == 0) begin
                $error("unexpected output word %h", got.word);
                errors++;
                return;
            end
            exp_w = pending_words.pop_front();
            if (got.word !== exp_w.word) begin
                $error("out_word: expected %h, got %h", exp_w.word, got.word); errors++;
            end
            if (got.count !== exp_w.count) begin
                $error("out_count: expected %0d, got %0d", exp_w.count, got.count); errors++;
            end
            if (got.last !== exp_w.last) begin
                $error("out_last: expected %0d, got %0d", exp_w.last, got.last); errors++;
            end
            if (got.action !== exp_w.action) begin
                $error("out_action: expected %0d, got %0d", exp_w.action, got.action); errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // in_word[63:0], in_count[67:64], zero[71:68]
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;   // out_word[63:0], out_count[67:64], zero[71:68]
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;   // out_action[1:0]
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    ndp_ipv6_in_ipv6_encapsulator uut (.*);

    ndp_scoreboard sb;
    int            quiet_cycles;
    int            stall_mode;
    logic [7:0]    frame_bytes [];

    // Generate the clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Check output words and drive a receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_output('{m_axis_tdata[63:0], m_axis_tdata[67:64],
                                  m_axis_tlast, m_axis_tuser});
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    // Watchdog: count cycles with no accepted word on any channel
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [3:0] idx, logic [63:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.regs[idx] = val;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending_words.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Send one word; s_axis_tvalid stays high between back-to-back words
    task automatic send_word(logic [63:0] w, logic [3:0] c, logic l);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, c, w};
        s_axis_tlast  <= l;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(w, c, l);
    endtask

    // Send frame_bytes as words, with random gaps inside the frame
    task automatic send_frame(logic [3:0] last_count_override);
        int unsigned nw, rem;
        logic [63:0] w;
        logic [3:0]  c;
        nw = (frame_bytes.size() + 7) / 8;
        for (int i = 0; i < nw; i++) begin
            w = 64'($urandom()) << 32 | 64'($urandom());
            for (int b = 0; b < 8; b++)
                if (i * 8 + b < frame_bytes.size()) w[56 - 8 * b +: 8] = frame_bytes[i * 8 + b];
            rem = frame_bytes.size() - i * 8;
            c = (i == nw - 1) ? 4'(rem) : 4'($urandom_range(0, 15));
            if (i == nw - 1 && last_count_override != 0) c = last_count_override;
            send_word(w, c, i == nw - 1);
            if ($urandom_range(0, 5) == 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
        end
        if ($urandom_range(0, 2) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Build a neighbour-discovery frame; kind: 0 solicitation, 1 advertisement
    task automatic build_nd(int len, int kind, logic [15:0] plen, int flaw);
        logic [63:0] thi, tlo;
        frame_bytes = new[len];
        foreach (frame_bytes[i]) frame_bytes[i] = 8'($urandom());
        frame_bytes[12] = 8'h86; frame_bytes[13] = 8'hDD;
        frame_bytes[14] = {4'd6, frame_bytes[14][3:0]};
        frame_bytes[18] = plen[15:8]; frame_bytes[19] = plen[7:0];
        frame_bytes[20] = NH_ICMPV6;
        frame_bytes[54] = kind ? ICMP_NADV : ICMP_NSOL;
        thi = kind ? sb.regs[REG_LOCAL_TARGET_HI] : sb.regs[REG_REMOTE_TARGET_HI];
        tlo = kind ? sb.regs[REG_LOCAL_TARGET_LO] : sb.regs[REG_REMOTE_TARGET_LO];
        for (int i = 0; i < 8; i++) begin
            frame_bytes[62 + i] = thi[56 - 8 * i +: 8];
            frame_bytes[70 + i] = tlo[56 - 8 * i +: 8];
        end
        // Break one classification condition
        case (flaw)
            1: frame_bytes[13] = 8'hDE;
            2: frame_bytes[14] = 8'h45;
            3: frame_bytes[20] = 8'd17;
            4: frame_bytes[54] = 8'd134;
            5: frame_bytes[70 + $urandom_range(0, 7)] ^= 8'h01;
            6: frame_bytes[12] = 8'h08;
            default: ;
        endcase
    endtask

    task automatic program_regs(int style);
        logic [63:0] v;
        for (int r = 0; r < NumRegs; r++) begin
            case (style)
                0: v = '0;
                1: v = '1;
                default: v = 64'($urandom()) << 32 | 64'($urandom());
            endcase
            write_reg(4'(r), v);
        end
    endtask

    initial begin
        logic [15:0] plen;
        int len, kind, flaw, sel;
        sb = new();
        sb.reset_state();
        quiet_cycles = 0;
        stall_mode = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tlast = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: all-ones addresses, then the corner cases
        program_regs(1);
        build_nd(78, 0, 16'd0, 0);      send_frame(0);
        build_nd(78, 1, 16'd65495, 0);  send_frame(0);
        build_nd(86, 0, 16'd65496, 0);  send_frame(0);
        build_nd(120, 1, 16'hFFFF, 0);  send_frame(0);
        build_nd(77, 0, 16'd32, 0);     send_frame(0);
        for (int f = 1; f <= 6; f++) begin
            build_nd(80, f & 1, 16'd32, f); send_frame(0);
        end
        build_nd(80, 0, 16'd32, 0);     send_frame(4'd0);
        build_nd(79, 1, 16'd32, 0);     send_frame(4'd15);
        build_nd(200, 0, 16'd1000, 0);  send_frame(0);
        frame_bytes = new[1]; frame_bytes[0] = 8'hFF; send_frame(0);
        frame_bytes = new[8]; foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
        send_frame(0);
        frame_bytes = new[13]; foreach (frame_bytes[i]) frame_bytes[i] = 8'($urandom());
        send_frame(0);
        s_axis_tvalid <= 1'b0;
        drain();

        // Random phases under several register settings
        for (int ph = 0; ph < 4; ph++) begin
            program_regs(ph == 0 ? 0 : 2);
            stall_mode = ph % 3;
            for (int fr = 0; fr < 2; fr++) begin
                sel = $urandom_range(0, 9);
                if (sel < 6) begin
                    len = $urandom_range(0, 3) == 0 ? $urandom_range(78, 160)
                                                    : $urandom_range(78, 90);
                    kind = $urandom_range(0, 1);
                    plen = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(65490, 65535))
                                                       : 16'($urandom());
                    if (plen > MAX_INNER_LEN && $urandom_range(0, 1)) plen = 16'd64;
                    flaw = $urandom_range(0, 4) == 0 ? $urandom_range(1, 6) : 0;
                    build_nd(len, kind, plen, flaw);
                end else begin
                    frame_bytes = new[$urandom_range(1, 100)];
                    foreach (frame_bytes[i]) frame_bytes[i] = 8'($urandom());
                end
                send_frame(0);
            end
            s_axis_tvalid <= 1'b0;
            drain();
        end

        program_regs(1);
        stall_mode = 2;
        drain();
        if (sb.errors == 0 && sb.pending_words.size() == 0) begin
            $display("PASS");
        end else begin
            if (sb.pending_words.size() != 0)
                $error("%0d expected words never arrived", sb.pending_words.size());
            $display("FAIL");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
sv/ndpe_pkg.sv
sv/ndpe_cfg.sv
sv/ndpe_class.sv
sv/ndp_ipv6_in_ipv6_encapsulator.sv
sv/ndpe_checker.sv
bench/testbench.sv
